/* rtl/ale_pkg.sv */
// ----------------------------------------------------------------------------
// ale_pkg
// Shared widths, action and status codes, and the cell command and
// result types of the ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ale_pkg;

   // field widths
   localparam int DATA_W    = 32;
   localparam int POS_W     = 9;
   localparam int ACT_W     = 4;
   localparam int STAT_W    = 2;
   localparam int DEPTH_DEF = 256;

   // actions
   localparam logic [ACT_W-1:0] ACT_APPEND    = 4'd0;
   localparam logic [ACT_W-1:0] ACT_PREPEND   = 4'd1;
   localparam logic [ACT_W-1:0] ACT_INSERT    = 4'd2;
   localparam logic [ACT_W-1:0] ACT_POP_LAST  = 4'd3;
   localparam logic [ACT_W-1:0] ACT_POP_FIRST = 4'd4;
   localparam logic [ACT_W-1:0] ACT_ERASE     = 4'd5;
   localparam logic [ACT_W-1:0] ACT_FIND      = 4'd6;
   localparam logic [ACT_W-1:0] ACT_READ      = 4'd7;
   localparam logic [ACT_W-1:0] ACT_OVERWRITE = 4'd8;
   localparam logic [ACT_W-1:0] ACT_CLEAR     = 4'd9;

   // result status
   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

   // per-cell data operation
   typedef logic [1:0] op_type;
   localparam op_type OP_HOLD  = 2'd0;
   localparam op_type OP_UP    = 2'd1;  // open a gap at the slot
   localparam op_type OP_DOWN  = 2'd2;  // close the gap at the slot
   localparam op_type OP_WRITE = 2'd3;  // overwrite the slot

   // broadcast command to every cell
   typedef struct packed {
      op_type            op;
      logic [DATA_W-1:0] value;       // entry to load, or key for a find
      logic              scan_start;  // clear the result chain
      logic              scan_step;   // advance the result chain one cell
      logic              scan_find;   // match on key instead of slot
   } cmd_type;

   // result travelling down the chain toward cell 0
   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] data;
      logic [POS_W-1:0]  pos;
   } res_type;

endpackage

`default_nettype wire

/* rtl/ale_cell.sv */
// ----------------------------------------------------------------------------
// ale_cell
// One list slot: holds an entry, shifts it to or from its neighbors and
// forwards the first match of a scan toward the head of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_cell #(
   parameter int DEPTH = ale_pkg::DEPTH_DEF,
   parameter int INDEX = 0
) (
   input  wire logic                           clock,
   input  wire ale_pkg::cmd_type               cmd,
   input  wire logic [$clog2(DEPTH)-1:0]       slot,
   input  wire logic [$clog2(DEPTH+1)-1:0]     count,
   input  wire logic [ale_pkg::DATA_W-1:0]     left_data,
   input  wire logic [ale_pkg::DATA_W-1:0]     right_data,
   input  wire ale_pkg::res_type               right_res,
   output logic [ale_pkg::DATA_W-1:0]          data,
   output ale_pkg::res_type                    res
);
   import ale_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam logic [IW-1:0]    MY_SLOT = IW'(INDEX);
   localparam logic [CW-1:0]    MY_CNT  = CW'(INDEX);
   localparam logic [POS_W-1:0] MY_POS  = POS_W'(INDEX + 1);

   logic [DATA_W-1:0] data_ff, data_in;
   res_type           res_ff, res_in;
   logic              hit;

   // entry update
   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         OP_UP: begin
            if (MY_SLOT > slot) data_in = left_data;
            else if (MY_SLOT == slot) data_in = cmd.value;
         end
         OP_DOWN: begin
            if (MY_SLOT >= slot) data_in = right_data;
         end
         OP_WRITE: begin
            if (MY_SLOT == slot) data_in = cmd.value;
         end
         default: data_in = data_ff;
      endcase
   end

   // local match for find or read
   assign hit = cmd.scan_find ? ((data_ff == cmd.value) && (MY_CNT < count))
                              : (MY_SLOT == slot);

   // result chain: nearer hit wins over what comes from the right
   always_comb begin
      res_in = res_ff;
      if (cmd.scan_start) begin
         res_in = '0;
      end else if (cmd.scan_step) begin
         if (hit) begin
            res_in.hit  = 1'b1;
            res_in.data = data_ff;
            res_in.pos  = MY_POS;
         end else begin
            res_in = right_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      res_ff  <= res_in;
   end

   assign data = data_ff;
   assign res  = res_ff;

endmodule

`default_nettype wire

/* rtl/array_list_engine_core.sv */
// Response: registered in the cycle after acceptance, except a find on a
//   non-empty list or an in-range read, which waits while the match walks the chain.
// Throughput: one shifting action per cycle while the response is taken;
//   such a find or read holds the input until its match reaches cell 0.
// Reset: synchronous, clears the entry count, control and output valid;
//   cell contents are not reset and are never read before written.
// ----------------------------------------------------------------------------
// array_list_engine_core
// Ordered list of signed 32-bit entries held in a chain of cells, with
// append, prepend, insert, pop, erase, find, read, overwrite and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_engine_core #(
   parameter int DEPTH = ale_pkg::DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ale_pkg::ACT_W-1:0]     req_action,
   input  wire logic [ale_pkg::POS_W-1:0]     req_position,
   input  wire logic signed [ale_pkg::DATA_W-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [ale_pkg::DATA_W-1:0]  rsp_read_value,
   output logic [ale_pkg::POS_W-1:0]          rsp_found_position,
   output logic [ale_pkg::POS_W-1:0]          rsp_count_now,
   output logic [ale_pkg::STAT_W-1:0]         rsp_status
);
   import ale_pkg::*;

   localparam int IW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH+1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic              state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     scan_cnt_ff, scan_cnt_in;
   logic [IW-1:0]     slot_ff, slot_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic              find_ff, find_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_rd_ff, rsp_rd_in;
   logic [POS_W-1:0]  rsp_fp_ff, rsp_fp_in;
   logic [POS_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic [STAT_W-1:0] rsp_st_ff, rsp_st_in;

   logic              req_fire;
   logic              full, empty, pos_zero, ins_ok, at_ok;
   logic [CMPW-1:0]   pos_ext, cnt_ext, pos_m1;
   cmd_type           cmd;
   logic [IW-1:0]     slot;
   op_type            req_op;
   logic [IW-1:0]     req_slot;
   logic              req_scan;
   logic [STAT_W-1:0] req_st;
   logic [CW-1:0]     req_cnt;

   logic [DATA_W-1:0] cell_data [DEPTH];
   res_type           cell_res  [DEPTH];

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   // position checks against the current count
   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign pos_ext  = CMPW'(req_position);
   assign cnt_ext  = CMPW'(count_ff);
   assign pos_m1   = pos_ext - CMPW'(1);
   assign pos_zero = (req_position == '0);
   assign ins_ok   = !pos_zero && (pos_m1 <= cnt_ext);
   assign at_ok    = !pos_zero && (pos_ext <= cnt_ext);

   // action decode
   always_comb begin
      req_op   = OP_HOLD;
      req_slot = IW'(pos_m1);
      req_scan = 1'b0;
      req_st   = STAT_OK;
      req_cnt  = count_ff;
      case (req_action)
         ACT_APPEND: begin
            if (full) req_st = STAT_FULL;
            else begin
               req_op   = OP_UP;
               req_slot = IW'(count_ff);
               req_cnt  = count_ff + CW'(1);
            end
         end
         ACT_PREPEND: begin
            if (full) req_st = STAT_FULL;
            else begin
               req_op   = OP_UP;
               req_slot = '0;
               req_cnt  = count_ff + CW'(1);
            end
         end
         ACT_INSERT: begin
            if (full) req_st = STAT_FULL;
            else if (!ins_ok) req_st = STAT_BADPOS;
            else begin
               req_op  = OP_UP;
               req_cnt = count_ff + CW'(1);
            end
         end
         ACT_POP_LAST: begin
            if (empty) req_st = STAT_EMPTY;
            else req_cnt = count_ff - CW'(1);
         end
         ACT_POP_FIRST: begin
            if (empty) req_st = STAT_EMPTY;
            else begin
               req_op   = OP_DOWN;
               req_slot = '0;
               req_cnt  = count_ff - CW'(1);
            end
         end
         ACT_ERASE: begin
            if (empty) req_st = STAT_EMPTY;
            else if (!at_ok) req_st = STAT_BADPOS;
            else begin
               req_op  = OP_DOWN;
               req_cnt = count_ff - CW'(1);
            end
         end
         ACT_FIND: begin
            if (!empty) req_scan = 1'b1;
         end
         ACT_READ: begin
            if (empty) req_st = STAT_EMPTY;
            else if (!at_ok) req_st = STAT_BADPOS;
            else req_scan = 1'b1;
         end
         ACT_OVERWRITE: begin
            if (empty) req_st = STAT_EMPTY;
            else if (!at_ok) req_st = STAT_BADPOS;
            else req_op = OP_WRITE;
         end
         ACT_CLEAR: begin
            req_cnt = '0;
         end
         default: begin
            req_op = OP_HOLD;
         end
      endcase
   end

   // command broadcast to the cells
   always_comb begin
      cmd            = '0;
      cmd.op         = OP_HOLD;
      cmd.value      = req_value;
      cmd.scan_find  = find_ff;
      slot           = req_slot;
      if (state_ff == ST_SCAN) begin
         cmd.value     = key_ff;
         cmd.scan_step = (scan_cnt_ff != '0);
         slot          = slot_ff;
      end else if (req_fire) begin
         cmd.op         = req_op;
         cmd.scan_start = req_scan;
      end
   end

   // sequencer and result register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_cnt_in  = scan_cnt_ff;
      slot_in      = slot_ff;
      key_in       = key_ff;
      find_in      = find_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_rd_in    = rsp_rd_ff;
      rsp_fp_in    = rsp_fp_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_st_in    = rsp_st_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               count_in = req_cnt;
               if (req_scan) begin
                  state_in    = ST_SCAN;
                  scan_cnt_in = count_ff;
                  slot_in     = req_slot;
                  key_in      = req_value;
                  find_in     = (req_action == ACT_FIND);
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_rd_in    = '0;
                  rsp_fp_in    = '0;
                  rsp_cnt_in   = POS_W'(req_cnt);
                  rsp_st_in    = req_st;
               end
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff != '0) begin
               scan_cnt_in = scan_cnt_ff - CW'(1);
            end else begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_cnt_in   = POS_W'(count_ff);
               rsp_st_in    = STAT_OK;
               if (find_ff) begin
                  rsp_rd_in = '0;
                  rsp_fp_in = cell_res[0].hit ? cell_res[0].pos : '0;
               end else begin
                  rsp_rd_in = cell_res[0].data;
                  rsp_fp_in = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_cnt_ff  <= '0;
         find_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_cnt_ff  <= scan_cnt_in;
         find_ff      <= find_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      key_ff     <= key_in;
      rsp_rd_ff  <= rsp_rd_in;
      rsp_fp_ff  <= rsp_fp_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_st_ff  <= rsp_st_in;
   end

   // chain of cells, slot 0 at the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_data, right_data;
      res_type           right_res;

      if (i == 0) begin : g_head
         assign left_data = '0;
      end else begin : g_mid
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH-1) begin : g_tail
         assign right_data = '0;
         assign right_res  = '0;
      end else begin : g_body
         assign right_data = cell_data[i+1];
         assign right_res  = cell_res[i+1];
      end

      ale_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .slot       (slot),
         .count      (count_ff),
         .left_data  (left_data),
         .right_data (right_data),
         .right_res  (right_res),
         .data       (cell_data[i]),
         .res        (cell_res[i])
      );
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_rd_ff;
   assign rsp_found_position = rsp_fp_ff;
   assign rsp_count_now      = rsp_cnt_ff;
   assign rsp_status         = rsp_st_ff;

endmodule

`default_nettype wire

/* test/tb_array_list_engine_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_array_list_engine_core
// Self-checking bench for the ordered list engine. A scoreboard keeps its
// own copy of the list, predicts the response of every accepted request and
// compares responses field by field. Directed corner cases come first. The
// random traffic that follows covers four handshake idling phases and two
// fills to capacity.
// ----------------------------------------------------------------------------

module tb_array_list_engine_core;
   import ale_pkg::*;

   localparam int DEPTH          = DEPTH_DEF;
   localparam int ITEMS_PER_PASS = 370;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = DEPTH + 40;
   localparam int PEND_DEPTH     = 16;

   typedef struct {
      logic signed [DATA_W-1:0] read_value;
      logic [POS_W-1:0]         found_position;
      logic [POS_W-1:0]         count_now;
      logic [STAT_W-1:0]        status;
   } rsp_fields_type;

   // list shadow, response predictor and pending response ring
   class list_scoreboard_type;
      logic signed [DATA_W-1:0] entries [DEPTH];
      int                       n_entries = 0;
      rsp_fields_type           pend_ring [PEND_DEPTH];
      int unsigned              pend_wr = 0;
      int unsigned              pend_rd = 0;
      int unsigned              n_pending = 0;
      int unsigned              n_errors = 0;
      int unsigned              n_requests = 0;
      int unsigned              n_checked = 0;
      int unsigned              peak_entries = 0;
      int unsigned              status_hits [4] = '{0, 0, 0, 0};

      // apply one request to the shadow list and queue its response
      function void note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                 logic signed [DATA_W-1:0] val);
         rsp_fields_type r;
         int             slot;
         int             p;
         r.read_value     = '0;
         r.found_position = '0;
         r.status         = STAT_OK;
         p = int'(pos);
         case (act)
            ACT_APPEND, ACT_PREPEND, ACT_INSERT: begin
               if (n_entries >= DEPTH) begin
                  r.status = STAT_FULL;
               end else if (act == ACT_INSERT && (p < 1 || p > n_entries + 1)) begin
                  r.status = STAT_BADPOS;
               end else begin
                  slot = (act == ACT_APPEND) ? n_entries : (act == ACT_PREPEND) ? 0 : p - 1;
                  for (int i = n_entries; i > slot; i--)
                     entries[i] = entries[i-1];
                  entries[slot] = val;
                  n_entries++;
               end
            end
            ACT_POP_LAST, ACT_POP_FIRST: begin
               if (n_entries == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  if (act == ACT_POP_FIRST)
                     for (int i = 1; i < n_entries; i++)
                        entries[i-1] = entries[i];
                  n_entries--;
               end
            end
            ACT_ERASE, ACT_READ, ACT_OVERWRITE: begin
               if (n_entries == 0) begin
                  r.status = STAT_EMPTY;
               end else if (p < 1 || p > n_entries) begin
                  r.status = STAT_BADPOS;
               end else if (act == ACT_ERASE) begin
                  for (int i = p; i < n_entries; i++)
                     entries[i-1] = entries[i];
                  n_entries--;
               end else if (act == ACT_READ) begin
                  r.read_value = entries[p-1];
               end else begin
                  entries[p-1] = val;
               end
            end
            ACT_FIND: begin
               for (int i = 0; i < n_entries; i++)
                  if (r.found_position == 0 && entries[i] == val)
                     r.found_position = POS_W'(i + 1);
            end
            ACT_CLEAR: n_entries = 0;
            default: ;
         endcase
         r.count_now = POS_W'(n_entries);
         if (n_entries > peak_entries)
            peak_entries = n_entries;
         status_hits[r.status]++;
         n_requests++;
         if (n_pending == PEND_DEPTH) begin
            $display("%0t prediction ring overflow", $time);
            n_errors++;
         end else begin
            pend_ring[pend_wr] = r;
            pend_wr = (pend_wr + 1) % PEND_DEPTH;
            n_pending++;
         end
      endfunction

      function void field_check(string name, longint want, longint got);
         if (want != got) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
            n_errors++;
         end
      endfunction

      // compare one accepted response with the oldest prediction
      function void check_response(logic signed [DATA_W-1:0] rd, logic [POS_W-1:0] fp,
                                   logic [POS_W-1:0] cnt, logic [STAT_W-1:0] st);
         rsp_fields_type want;
         if (n_pending == 0) begin
            $display("%0t unexpected response, nothing pending (count %0d status %0d)",
                     $time, cnt, st);
            n_errors++;
         end else begin
            want = pend_ring[pend_rd];
            pend_rd = (pend_rd + 1) % PEND_DEPTH;
            n_pending--;
            field_check("read_value", want.read_value, rd);
            field_check("found_position", want.found_position, fp);
            field_check("count_now", want.count_now, cnt);
            field_check("status", want.status, st);
            n_checked++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [ACT_W-1:0]         req_action = ACT_CLEAR;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [POS_W-1:0]         rsp_found_position;
   logic [POS_W-1:0]         rsp_count_now;
   logic [STAT_W-1:0]        rsp_status;

   int unsigned         req_idle_pct = 0;
   int unsigned         rsp_stall_pct = 0;
   int unsigned         quiet_cycles = 0;
   list_scoreboard_type sb = new();

   array_list_engine_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_count_now      (rsp_count_now),
      .rsp_status         (rsp_status)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // response side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // response check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_read_value, rsp_found_position, rsp_count_now, rsp_status);
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // one request transaction, with optional idle cycles ahead of it
   task automatic send_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_request(act, pos, val);
   endtask

   // entry values: small pool for duplicates, extremes, or fully random
   function automatic logic signed [DATA_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 40)
         return DATA_W'($urandom_range(7));
      else if (roll < 55)
         case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            default: return '1;
         endcase
      else
         return $urandom;
   endfunction

   // mostly well-formed actions at legal positions, some noise
   task automatic send_random();
      int unsigned              roll;
      int                       n;
      logic [ACT_W-1:0]         act;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] val;
      n    = sb.n_entries;
      roll = $urandom_range(99);
      if (roll < 18)      act = ACT_APPEND;
      else if (roll < 26) act = ACT_PREPEND;
      else if (roll < 38) act = ACT_INSERT;
      else if (roll < 44) act = ACT_POP_LAST;
      else if (roll < 50) act = ACT_POP_FIRST;
      else if (roll < 60) act = ACT_ERASE;
      else if (roll < 72) act = ACT_FIND;
      else if (roll < 82) act = ACT_READ;
      else if (roll < 90) act = ACT_OVERWRITE;
      else if (roll < 92) act = ACT_CLEAR;
      else if (roll < 95) act = ACT_W'($urandom_range(15, ACT_CLEAR + 1));
      else                act = ACT_INSERT;

      pos = POS_W'($urandom_range(511));
      if ($urandom_range(99) < 85) begin
         if (act == ACT_INSERT)
            pos = POS_W'($urandom_range(n + 1, 1));
         else if (n > 0 && (act == ACT_ERASE || act == ACT_READ || act == ACT_OVERWRITE))
            pos = POS_W'($urandom_range(n, 1));
      end

      val = pick_value();
      if (act == ACT_FIND && n > 0 && $urandom_range(99) < 60)
         val = sb.entries[$urandom_range(n - 1)];
      send_request(act, pos, val);
   endtask

   // fill the list to capacity, probe the full list, then clear it
   task automatic fill_to_capacity();
      while (sb.n_entries < DEPTH)
         send_request(ACT_APPEND, POS_W'($urandom_range(511)), pick_value());
      send_request(ACT_APPEND, 9'd1, pick_value());
      send_request(ACT_PREPEND, 9'd1, pick_value());
      send_request(ACT_INSERT, 9'd1, pick_value());
      send_request(ACT_INSERT, POS_W'(DEPTH + 1), pick_value());
      send_request(ACT_FIND, 9'd0, sb.entries[DEPTH-1]);
      send_request(ACT_FIND, 9'd0, 32'sh1234_5678);
      send_request(ACT_READ, POS_W'(DEPTH), '0);
      send_request(ACT_READ, POS_W'(DEPTH + 1), '0);
      send_request(ACT_ERASE, POS_W'(DEPTH), '0);
      send_request(ACT_INSERT, POS_W'(DEPTH), pick_value());
      send_request(ACT_OVERWRITE, 9'd1, pick_value());
      send_request(ACT_POP_FIRST, 9'd0, '0);
      send_request(ACT_POP_LAST, 9'd0, '0);
      send_request(ACT_CLEAR, 9'd0, '0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, unused actions, position limits, extremes
      send_request(ACT_POP_LAST, 9'd0, '0);
      send_request(ACT_POP_FIRST, 9'd0, '0);
      send_request(ACT_ERASE, 9'd1, '0);
      send_request(ACT_READ, 9'd1, '0);
      send_request(ACT_OVERWRITE, 9'd1, 32'sh0000_0001);
      send_request(ACT_FIND, 9'd0, '0);
      send_request(ACT_W'(10), 9'h1ff, '1);
      send_request(ACT_W'(15), 9'd3, 32'sh7fff_ffff);
      send_request(ACT_CLEAR, 9'd0, '0);
      send_request(ACT_INSERT, 9'd0, 32'sh0000_0011);
      send_request(ACT_INSERT, 9'd2, 32'sh0000_0012);
      send_request(ACT_APPEND, 9'd0, 32'sh7fff_ffff);
      send_request(ACT_PREPEND, 9'd0, 32'sh8000_0000);
      send_request(ACT_INSERT, 9'd3, '0);
      send_request(ACT_INSERT, 9'd3, '1);
      send_request(ACT_READ, 9'd0, '0);
      send_request(ACT_READ, 9'd5, '0);
      send_request(ACT_READ, 9'h1ff, '0);
      send_request(ACT_OVERWRITE, 9'd4, 32'sh5a5a_5a5a);
      send_request(ACT_FIND, 9'd0, '1);
      send_request(ACT_FIND, 9'd0, 32'sh0001_2345);
      send_request(ACT_ERASE, 9'd9, '0);
      send_request(ACT_ERASE, 9'd2, '0);
      send_request(ACT_READ, 9'd1, '0);
      send_request(ACT_POP_FIRST, 9'd0, '0);
      send_request(ACT_POP_LAST, 9'd0, '0);
      send_request(ACT_CLEAR, 9'd0, '0);

      // random traffic under four idling mixes
      for (int pass = 0; pass < 4; pass++) begin
         case (pass)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 46; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 46; end
            default: begin req_idle_pct = 20; rsp_stall_pct = 20; end
         endcase
         if (pass == 0 || pass == 3)
            fill_to_capacity();
         repeat (ITEMS_PER_PASS)
            send_random();
      end
      req_valid <= 1'b0;

      // drain outstanding responses
      while (sb.n_pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.n_pending != 0) begin
         $display("%0t %0d responses never arrived", $time, sb.n_pending);
         sb.n_errors++;
      end

      $display("covered %0d requests and %0d checked responses, peak list length %0d",
               sb.n_requests, sb.n_checked, sb.peak_entries);
      $display("status seen: ok %0d, full %0d, empty %0d, bad position %0d, errors %0d",
               sb.status_hits[STAT_OK], sb.status_hits[STAT_FULL],
               sb.status_hits[STAT_EMPTY], sb.status_hits[STAT_BADPOS], sb.n_errors);
      if (sb.n_errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/ale_pkg.sv
rtl/ale_cell.sv
rtl/array_list_engine_core.sv
test/tb_array_list_engine_core.sv
